// ===== hw/rtl/tdvg_pkg.sv =====
// Shared types and constants of the teleop deadman velocity gate.
`default_nettype none

package tdvg_pkg;

	localparam int AXIS_W   = 16;
	localparam int CMD_W    = 17;
	localparam int GAIN_W   = 16;
	localparam int DZ_W     = 15;
	localparam int TICK_W   = 16;
	localparam int BIT_W    = 3;
	localparam int BTN_W    = 8;
	localparam int QUO_W    = 16;
	localparam int REM_W    = 17;
	localparam int PROD_W   = GAIN_W + QUO_W;
	localparam int FRAC_W   = 15;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W    = $clog2(DIV_STEPS);
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	// One in Q0.15, and the wrap point for the magnitude of a negative axis
	localparam logic [REM_W-1:0] FULL_SCALE = 17'h08000;
	localparam logic [REM_W-1:0] WRAP       = 17'h10000;

	// Register indexes (word address)
	localparam logic [2:0] REG_DEADMAN_BIT    = 3'd0;
	localparam logic [2:0] REG_TURBO_BIT      = 3'd1;
	localparam logic [2:0] REG_LINEAR_GAIN    = 3'd2;
	localparam logic [2:0] REG_ANGULAR_GAIN   = 3'd3;
	localparam logic [2:0] REG_TURBO_LIN_GAIN = 3'd4;
	localparam logic [2:0] REG_TURBO_ANG_GAIN = 3'd5;
	localparam logic [2:0] REG_DEAD_BAND      = 3'd6;
	localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd7;

	typedef enum logic [1:0] {
		CAUSE_DRIVE   = 2'd0,
		CAUSE_DEADMAN = 2'd1,
		CAUSE_BAD     = 2'd2,
		CAUSE_TIMEOUT = 2'd3
	} cause_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_PREP,
		ST_DIV,
		ST_MUL,
		ST_STORE,
		ST_STOP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [BIT_W-1:0]  deadman_bit;
		logic [BIT_W-1:0]  turbo_bit;
		logic [GAIN_W-1:0] linear_gain;
		logic [GAIN_W-1:0] angular_gain;
		logic [GAIN_W-1:0] turbo_linear_gain;
		logic [GAIN_W-1:0] turbo_angular_gain;
		logic [DZ_W-1:0]   dead_band;
		logic [TICK_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic   load;
		logic   idle_clr;
		logic   idle_inc;
		logic   prep;
		logic   div_step;
		logic   mul;
		logic   store;
		logic   axis;
		logic   emit;
		cause_t cause;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic msg_bad;
		logic deadman;
		logic timeout_hit;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdvg_if.sv =====
// Input and result channel interfaces of the velocity gate.
`default_nettype none

interface tdvg_in_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic [7:0]        buttons;
	logic signed [15:0] stick_ly;
	logic signed [15:0] stick_lx;
	logic              msg_bad;

	modport source (output valid, func, buttons, stick_ly, stick_lx, msg_bad, input ready);
	modport sink (input valid, func, buttons, stick_ly, stick_lx, msg_bad, output ready);
endinterface

interface tdvg_out_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] linear_cmd;
	logic signed [16:0] angular_cmd;
	logic [1:0]         cause;

	modport source (output valid, linear_cmd, angular_cmd, cause, input ready);
	modport sink (input valid, linear_cmd, angular_cmd, cause, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tdvg_regs.sv =====
// APB configuration register file of the velocity gate.
`default_nettype none

module tdvg_regs
	import tdvg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready,
	output      cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadman_bit        <= 3'd0;
			cfg_q.turbo_bit          <= 3'd1;
			cfg_q.linear_gain        <= 16'd205;
			cfg_q.angular_gain       <= 16'd1229;
			cfg_q.turbo_linear_gain  <= 16'd410;
			cfg_q.turbo_angular_gain <= 16'd2458;
			cfg_q.dead_band          <= 15'd3277;
			cfg_q.timeout_ticks      <= 16'd5;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEADMAN_BIT:    cfg_q.deadman_bit        <= pwdata[BIT_W-1:0];
				REG_TURBO_BIT:      cfg_q.turbo_bit          <= pwdata[BIT_W-1:0];
				REG_LINEAR_GAIN:    cfg_q.linear_gain        <= pwdata[GAIN_W-1:0];
				REG_ANGULAR_GAIN:   cfg_q.angular_gain       <= pwdata[GAIN_W-1:0];
				REG_TURBO_LIN_GAIN: cfg_q.turbo_linear_gain  <= pwdata[GAIN_W-1:0];
				REG_TURBO_ANG_GAIN: cfg_q.turbo_angular_gain <= pwdata[GAIN_W-1:0];
				REG_DEAD_BAND:      cfg_q.dead_band          <= pwdata[DZ_W-1:0];
				REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks      <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEADMAN_BIT:    prdata = DATA_W'(cfg_q.deadman_bit);
			REG_TURBO_BIT:      prdata = DATA_W'(cfg_q.turbo_bit);
			REG_LINEAR_GAIN:    prdata = DATA_W'(cfg_q.linear_gain);
			REG_ANGULAR_GAIN:   prdata = DATA_W'(cfg_q.angular_gain);
			REG_TURBO_LIN_GAIN: prdata = DATA_W'(cfg_q.turbo_linear_gain);
			REG_TURBO_ANG_GAIN: prdata = DATA_W'(cfg_q.turbo_angular_gain);
			REG_DEAD_BAND:      prdata = DATA_W'(cfg_q.dead_band);
			REG_TIMEOUT_TICKS:  prdata = DATA_W'(cfg_q.timeout_ticks);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tdvg_dp.sv =====
// Datapath: input word, idle counter, serial divider, shared multiplier, result register.
`default_nettype none

module tdvg_dp
	import tdvg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire dp_cmd_t            cmd,
	output      dp_stat_t           stat,
	input  wire logic               in_func,
	input  wire logic [BTN_W-1:0]   in_buttons,
	input  wire logic [AXIS_W-1:0]  in_stick_ly,
	input  wire logic [AXIS_W-1:0]  in_stick_lx,
	input  wire logic               in_msg_bad,
	output      logic [CMD_W-1:0]   out_linear,
	output      logic [CMD_W-1:0]   out_angular,
	output      cause_t             out_cause
);

	logic               func_q, bad_q, deadman_q;
	logic [AXIS_W-1:0]  ly_q, lx_q;
	logic [GAIN_W-1:0]  gain_lin_q, gain_ang_q;
	logic [TICK_W-1:0]  idle_q;
	logic [REM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   den_q;
	logic [QUO_W-1:0]   quo_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CMD_W-1:0]   lin_q, ang_q;
	logic [CMD_W-1:0]   out_lin_q, out_ang_q;
	cause_t             out_cause_q;

	logic               turbo;
	logic [TICK_W-1:0]  idle_next;
	logic [AXIS_W-1:0]  axis_v;
	logic [REM_W-1:0]   mag, dz;
	logic [REM_W-1:0]   rem_diff;
	logic               rem_ge;
	logic [CMD_W-1:0]   cmd_mag, cmd_signed;

	assign turbo     = in_buttons[cfg.turbo_bit];
	assign idle_next = (idle_q == {TICK_W{1'b1}}) ? idle_q : idle_q + 1'b1;

	assign stat.func        = func_q;
	assign stat.msg_bad     = bad_q;
	assign stat.deadman     = deadman_q;
	assign stat.timeout_hit = idle_next > cfg.timeout_ticks;

	// magnitude of the selected axis; the most negative code maps to full scale
	assign axis_v = cmd.axis ? lx_q : ly_q;
	assign mag    = axis_v[AXIS_W-1] ? WRAP - {1'b0, axis_v} : {1'b0, axis_v};
	assign dz     = {{(REM_W-DZ_W){1'b0}}, cfg.dead_band};

	// one restoring step; remainder stays below twice the divisor
	assign rem_ge   = rem_q >= {1'b0, den_q};
	assign rem_diff = rem_ge ? rem_q - {1'b0, den_q} : rem_q;

	assign cmd_mag    = prod_q[PROD_W-1:FRAC_W];
	assign cmd_signed = neg_q ? CMD_W'(~cmd_mag + 1'b1) : cmd_mag;

	assign out_linear  = out_lin_q;
	assign out_angular = out_ang_q;
	assign out_cause   = out_cause_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
		end else if (cmd.idle_clr) begin
			idle_q <= '0;
		end else if (cmd.idle_inc) begin
			idle_q <= idle_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= in_func;
			bad_q      <= in_msg_bad;
			deadman_q  <= in_buttons[cfg.deadman_bit];
			ly_q       <= in_stick_ly;
			lx_q       <= in_stick_lx;
			gain_lin_q <= turbo ? cfg.turbo_linear_gain : cfg.linear_gain;
			gain_ang_q <= turbo ? cfg.turbo_angular_gain : cfg.angular_gain;
		end
		if (cmd.prep) begin
			// inside the dead band the numerator is zero, so the quotient is zero
			rem_q <= (mag > dz) ? mag - dz : '0;
			den_q <= QUO_W'(FULL_SCALE - dz);
			neg_q <= axis_v[AXIS_W-1];
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			// numerator never exceeds divisor, so the quotient tops out at full scale
			rem_q <= {rem_diff[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], rem_ge};
		end
		if (cmd.mul) begin
			prod_q <= (cmd.axis ? gain_ang_q : gain_lin_q) * quo_q;
		end
		if (cmd.store) begin
			if (cmd.axis) begin
				ang_q <= cmd_signed;
			end else begin
				lin_q <= cmd_signed;
			end
		end
		if (cmd.emit) begin
			out_lin_q   <= (cmd.cause == CAUSE_DRIVE) ? lin_q : '0;
			out_ang_q   <= (cmd.cause == CAUSE_DRIVE) ? ang_q : '0;
			out_cause_q <= cmd.cause;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tdvg_ctrl.sv =====
// Controller: sequences each word and keeps the deadman and watchdog flags.
`default_nettype none

module tdvg_ctrl
	import tdvg_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output      logic     in_ready,
	output      logic     out_valid,
	input  wire logic     out_ready,
	input  wire dp_stat_t stat,
	output      dp_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic             axis_q;
	logic [CNT_W-1:0] cnt_q;
	cause_t           cause_q;
	logic             seen_q, latched_q, driving_q;
	logic             out_valid_q;
	logic             out_free;
	logic             tick_live;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign tick_live = seen_q && !latched_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_EVAL;
			ST_EVAL: begin
				if (stat.func) begin
					state_d = (tick_live && stat.timeout_hit) ? ST_STOP : ST_IDLE;
				end else if (stat.msg_bad) begin
					state_d = ST_STOP;
				end else if (!stat.deadman) begin
					state_d = driving_q ? ST_STOP : ST_IDLE;
				end else begin
					state_d = ST_PREP;
				end
			end
			ST_PREP:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == '0) state_d = ST_MUL;
			ST_MUL:   state_d = ST_STORE;
			ST_STORE: state_d = axis_q ? ST_EMIT : ST_PREP;
			ST_STOP:  if (out_free) state_d = ST_IDLE;
			ST_EMIT:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.axis     = axis_q;
		cmd.cause    = CAUSE_DRIVE;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.idle_clr = (state_q == ST_EVAL) && !stat.func;
		cmd.idle_inc = (state_q == ST_EVAL) && stat.func && tick_live;
		cmd.prep     = (state_q == ST_PREP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.mul      = (state_q == ST_MUL);
		cmd.store    = (state_q == ST_STORE);
		if (state_q == ST_STOP) begin
			cmd.emit  = out_free;
			cmd.cause = cause_q;
		end else if (state_q == ST_EMIT) begin
			cmd.emit  = out_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			cause_q     <= CAUSE_DRIVE;
			seen_q      <= 1'b0;
			latched_q   <= 1'b0;
			driving_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_EVAL: begin
					axis_q <= 1'b0;
					if (stat.func) begin
						if (tick_live && stat.timeout_hit) begin
							latched_q <= 1'b1;
							cause_q   <= CAUSE_TIMEOUT;
						end
					end else begin
						seen_q    <= 1'b1;
						latched_q <= 1'b0;
						cause_q   <= stat.msg_bad ? CAUSE_BAD : CAUSE_DEADMAN;
					end
				end
				ST_PREP:  cnt_q <= CNT_W'(DIV_STEPS - 1);
				ST_DIV:   cnt_q <= cnt_q - 1'b1;
				ST_STORE: axis_q <= 1'b1;
				ST_STOP:  if (out_free) driving_q <= 1'b0;
				ST_EMIT:  if (out_free) driving_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/teleop_deadman_velocity_gate.sv =====
// Top level of the teleop deadman velocity gate.
//
// in_ch carries one word per gamepad sample (func = 0) or watchdog tick
// (func = 1). out_ch carries zero or one velocity word per input word:
// a drive command (cause 0) or a stop (cause 1 deadman released, 2 bad
// sample, 3 timeout) with both commands zero. The APB port holds the eight
// configuration registers at byte addresses 0x00..0x1C; write only while idle.
//
// A stop passes the EVAL and STOP states before it is valid on out_ch;
// a drive word passes EVAL, then PREP, DIV, MUL and STORE once per stick
// axis, set by the 16-step serial divider and the single multiplier, and
// then EMIT; a word that gives no result goes from EVAL back to IDLE. One
// word is in work at a time; in_ch.ready is high only while the controller
// waits for a word.
// The result register lets the next word be accepted while a result waits;
// if out_ch stalls, the next result holds in the controller until it drains.
// Reset clears the watchdog count, the flags and out_ch.valid, and loads
// the registers with their defaults.
`default_nettype none

module teleop_deadman_velocity_gate
	import tdvg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output      logic [DATA_W-1:0] prdata,
	output      logic              pready,
	tdvg_in_if.sink                in_ch,
	tdvg_out_if.source             out_ch
);

	cfg_t             cfg;
	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [CMD_W-1:0] lin_cmd, ang_cmd;
	cause_t           cause;

	tdvg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequence each word and own the handshakes
	tdvg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// deadzone removal, rescale and gain for both axes
	tdvg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.stat        (stat),
		.in_func     (in_ch.func),
		.in_buttons  (in_ch.buttons),
		.in_stick_ly (in_ch.stick_ly),
		.in_stick_lx (in_ch.stick_lx),
		.in_msg_bad  (in_ch.msg_bad),
		.out_linear  (lin_cmd),
		.out_angular (ang_cmd),
		.out_cause   (cause)
	);

	assign out_ch.linear_cmd  = lin_cmd;
	assign out_ch.angular_cmd = ang_cmd;
	assign out_ch.cause       = cause;

endmodule

`default_nettype wire
